/* sv/nrpf_pkg.sv */
// ----------------------------------------------------------------------------
// nrpf_pkg
// Constants, types and helpers for the nearest-neighbor rotation pixel fetch.
// ----------------------------------------------------------------------------
package nrpf_pkg;

	localparam int MAX_WIDTH      = 512;
	localparam int MAX_HEIGHT     = 512;
	localparam int COEF_FRAC_BITS = 14;

	localparam int XW          = $clog2(MAX_WIDTH);
	localparam int YW          = $clog2(MAX_HEIGHT);
	localparam int AW          = XW + YW;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int SIZE_W      = 10;
	localparam int COEF_W      = 16;
	localparam int PIX_W       = 32;
	localparam int PADDR_W     = 4;
	localparam int PDATA_W     = 32;

	// centered coordinate, product, sum and integer-part widths
	localparam int CW     = ((XW > YW) ? XW : YW) + 2;
	localparam int PROD_W = CW + COEF_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int INT_W  = SUM_W - COEF_FRAC_BITS;

	localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(MAX_WIDTH);
	localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(MAX_HEIGHT);
	localparam logic [COEF_W-1:0] SIN_RST    = '0;
	localparam logic [COEF_W-1:0] COS_RST    = COEF_W'(1 << COEF_FRAC_BITS);

	typedef enum logic {
		ACT_LOAD  = 1'b0,
		ACT_FETCH = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_SIN    = 2'd2,
		REG_COS    = 2'd3
	} reg_idx_t;

	// register value 0 acts as 1, above the maximum acts as the maximum
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r,
		input logic [SIZE_W-1:0] lim);
		logic [SIZE_W-1:0] s;
		if (r == '0) begin
			s = SIZE_W'(1);
		end else if (r > lim) begin
			s = lim;
		end else begin
			s = r;
		end
		return s;
	endfunction

endpackage

/* sv/nearest_rotation_pixel_fetch_unit.sv */
// ----------------------------------------------------------------------------
// nearest_rotation_pixel_fetch_unit
// Loads pixels into a frame store and fetches the mirrored, rotated source
// pixel for each destination coordinate.
// ----------------------------------------------------------------------------
// A fetch beat raises done from the last pipeline stage, s5, with a registered result.
// Throughput: one beat per clock, loads and fetches mixed; busy is always low.
// The single frame store port is shared in stage 4 by load writes and fetch
// reads, so both keep their order. Reset clears the valid bits and loads the
// register defaults; frame store contents are undefined until written.
module nearest_rotation_pixel_fetch_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          action,
	input  logic [nrpf_pkg::XW-1:0]       coord_x,
	input  logic [nrpf_pkg::YW-1:0]       coord_y,
	input  logic [nrpf_pkg::PIX_W-1:0]    pixel_in,
	output logic                          done,
	output logic [nrpf_pkg::PIX_W-1:0]    pixel_out,
	output logic [nrpf_pkg::XW-1:0]       source_x,
	output logic [nrpf_pkg::YW-1:0]       source_y,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [nrpf_pkg::PADDR_W-1:0]  paddr,
	input  logic [nrpf_pkg::PDATA_W-1:0]  pwdata,
	output logic [nrpf_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import nrpf_pkg::*;

	// configuration
	logic [SIZE_W-1:0] width_q, height_q;
	logic [COEF_W-1:0] sin_q, cos_q;
	logic              cfg_wr;
	reg_idx_t          cfg_idx;

	logic [SIZE_W-1:0] w_eff, h_eff, wm1, hm1;
	logic [XW-1:0]     mid_x;
	logic [YW-1:0]     mid_y;

	// pipeline
	logic              vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	action_t           act_s1, act_s2, act_s3, act_s4, act_s5;
	logic [XW-1:0]     x_s1, x_s2, x_s3;
	logic [YW-1:0]     y_s1, y_s2, y_s3;
	logic [PIX_W-1:0]  pix_s1, pix_s2, pix_s3, pix_s4;
	logic signed [CW-1:0]     u_s1, v_s1;
	logic signed [PROD_W-1:0] us_s2, vc_s2, uc_s2, vs_s2;
	logic signed [SUM_W-1:0]  ax_s3, ay_s3;
	logic [AW-1:0]     addr_s4, addr_s5;
	logic [PIX_W-1:0]  rdata_s5;

	logic                    accept;
	logic signed [SUM_W-1:0] ax_c, ay_c;
	logic signed [INT_W-1:0] tx_c, ty_c;
	logic [XW-1:0]           cx_c, sx_c;
	logic [YW-1:0]           cy_c;
	logic [AW-1:0]           addr_c;

	logic [PIX_W-1:0] store [STORE_DEPTH];

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign accept = start & ~busy;

	// ---------------- configuration port ----------------
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			sin_q    <= SIN_RST;
			cos_q    <= COS_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_WIDTH:  width_q  <= pwdata[SIZE_W-1:0];
				REG_HEIGHT: height_q <= pwdata[SIZE_W-1:0];
				REG_SIN:    sin_q    <= pwdata[COEF_W-1:0];
				REG_COS:    cos_q    <= pwdata[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_WIDTH:  prdata = PDATA_W'(width_q);
			REG_HEIGHT: prdata = PDATA_W'(height_q);
			REG_SIN:    prdata = {{(PDATA_W-COEF_W){sin_q[COEF_W-1]}}, sin_q};
			REG_COS:    prdata = {{(PDATA_W-COEF_W){cos_q[COEF_W-1]}}, cos_q};
			default:    prdata = '0;
		endcase
	end

	assign w_eff = eff_size(width_q, SIZE_W'(MAX_WIDTH));
	assign h_eff = eff_size(height_q, SIZE_W'(MAX_HEIGHT));
	assign wm1   = w_eff - SIZE_W'(1);
	assign hm1   = h_eff - SIZE_W'(1);
	assign mid_x = XW'(w_eff >> 1);
	assign mid_y = YW'(h_eff >> 1);

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// ---------------- stage 3 combinational: integer part ----------------
	// truncation toward zero: floor, then +1 for negative values with a fraction
	assign ax_c = ax_s3;
	assign ay_c = ay_s3;
	assign tx_c = INT_W'(ax_c >>> COEF_FRAC_BITS)
		+ INT_W'(ax_c[SUM_W-1] && (ax_c[COEF_FRAC_BITS-1:0] != '0));
	assign ty_c = INT_W'(ay_c >>> COEF_FRAC_BITS)
		+ INT_W'(ay_c[SUM_W-1] && (ay_c[COEF_FRAC_BITS-1:0] != '0));

	always_comb begin
		if (tx_c < 0) begin
			cx_c = '0;
		end else if (tx_c > $signed({{(INT_W-SIZE_W){1'b0}}, wm1})) begin
			cx_c = XW'(wm1);
		end else begin
			cx_c = XW'(tx_c);
		end
		if (ty_c < 0) begin
			cy_c = '0;
		end else if (ty_c > $signed({{(INT_W-SIZE_W){1'b0}}, hm1})) begin
			cy_c = YW'(hm1);
		end else begin
			cy_c = YW'(ty_c);
		end
		sx_c = XW'(wm1) - cx_c;
		if (act_s3 == ACT_LOAD) begin
			addr_c = {y_s3, x_s3};
		end else begin
			addr_c = {cy_c, sx_c};
		end
	end

	// ---------------- pipeline payload ----------------
	always_ff @(posedge clk) begin
		// s1: capture and center
		act_s1 <= action_t'(action);
		x_s1   <= coord_x;
		y_s1   <= coord_y;
		pix_s1 <= pixel_in;
		u_s1   <= $signed(CW'(coord_x)) - $signed(CW'(mid_x));
		v_s1   <= $signed(CW'(coord_y)) - $signed(CW'(mid_y));
		// s2: products
		act_s2 <= act_s1;
		x_s2   <= x_s1;
		y_s2   <= y_s1;
		pix_s2 <= pix_s1;
		us_s2  <= u_s1 * $signed(sin_q);
		vc_s2  <= v_s1 * $signed(cos_q);
		uc_s2  <= u_s1 * $signed(cos_q);
		vs_s2  <= v_s1 * $signed(sin_q);
		// s3: sums with the center offset
		act_s3 <= act_s2;
		x_s3   <= x_s2;
		y_s3   <= y_s2;
		pix_s3 <= pix_s2;
		ax_s3  <= SUM_W'(us_s2) + SUM_W'(vc_s2)
			+ $signed(SUM_W'({mid_x, {COEF_FRAC_BITS{1'b0}}}));
		ay_s3  <= SUM_W'(uc_s2) - SUM_W'(vs_s2)
			+ $signed(SUM_W'({mid_y, {COEF_FRAC_BITS{1'b0}}}));
		// s4: store address
		act_s4  <= act_s3;
		pix_s4  <= pix_s3;
		addr_s4 <= addr_c;
		// s5: result
		act_s5  <= act_s4;
		addr_s5 <= addr_s4;
	end

	// frame store: one port, loads and fetches in beat order
	always_ff @(posedge clk) begin
		if (vld_s4) begin
			if (act_s4 == ACT_LOAD) begin
				store[addr_s4] <= pix_s4;
			end else begin
				rdata_s5 <= store[addr_s4];
			end
		end
	end

	assign done      = vld_s5 & (act_s5 == ACT_FETCH);
	assign pixel_out = rdata_s5;
	assign source_x  = addr_s5[XW-1:0];
	assign source_y  = addr_s5[AW-1:XW];

	// ---------------- assertions ----------------
	a_fetch_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (action == ACT_FETCH) |-> ##5 done)
		else $error("fetch beat did not complete after five cycles");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (action == ACT_LOAD) |-> ##5 !done)
		else $error("load beat produced a result");

	a_source_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (SIZE_W'(source_x) <= wm1) && (SIZE_W'(source_y) <= hm1))
		else $error("source coordinate outside active image");

endmodule

/* tb/sv/nearest_rotation_pixel_fetch_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_rotation_pixel_fetch_unit_tb
// Drives pixel loads and rotated fetches through the command port and writes
// the size and coefficient registers over APB. Each done beat is checked
// against a local rotate/mirror/clamp calculation over a shadow frame store.
// ----------------------------------------------------------------------------
module nearest_rotation_pixel_fetch_unit_tb;
	import nrpf_pkg::*;

	typedef struct {
		logic [PIX_W-1:0] pixel;
		logic [XW-1:0]    sx;
		logic [YW-1:0]    sy;
	} rot_pixel_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                action;
	logic [XW-1:0]       coord_x;
	logic [YW-1:0]       coord_y;
	logic [PIX_W-1:0]    pixel_in;
	logic                done;
	logic [PIX_W-1:0]    pixel_out;
	logic [XW-1:0]       source_x;
	logic [YW-1:0]       source_y;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// shadow registers and frame store
	logic [SIZE_W-1:0]        width_reg;
	logic [SIZE_W-1:0]        height_reg;
	logic signed [COEF_W-1:0] sin_reg;
	logic signed [COEF_W-1:0] cos_reg;
	logic [PIX_W-1:0]         frame_shadow [int];

	rot_pixel_t pending_pixels[$];
	int         mismatch_cnt;
	int         beats_sent;
	int         idle_pct;

	nearest_rotation_pixel_fetch_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .coord_x(coord_x), .coord_y(coord_y), .pixel_in(pixel_in),
		.done(done), .pixel_out(pixel_out), .source_x(source_x), .source_y(source_y),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #4 clk = ~clk;

	function automatic longint eff_dim(input logic [SIZE_W-1:0] r, input longint lim);
		if (r == 0) begin
			return 1;
		end else if (longint'(r) > lim) begin
			return lim;
		end
		return longint'(r);
	endfunction

	// integer part, rounded toward zero
	function automatic longint trunc_q(input longint a);
		if (a >= 0) begin
			return a >>> COEF_FRAC_BITS;
		end
		return -((-a) >>> COEF_FRAC_BITS);
	endfunction

	function automatic void rotated_source(input logic [XW-1:0] x, input logic [YW-1:0] y,
		output logic [XW-1:0] sx, output logic [YW-1:0] sy);
		longint w, h, mx, my, u, v, ax, ay, cx, cy;
		w  = eff_dim(width_reg, MAX_WIDTH);
		h  = eff_dim(height_reg, MAX_HEIGHT);
		mx = w / 2;
		my = h / 2;
		u  = longint'(x) - mx;
		v  = longint'(y) - my;
		ax = u * longint'(sin_reg) + v * longint'(cos_reg) + (mx <<< COEF_FRAC_BITS);
		ay = u * longint'(cos_reg) - v * longint'(sin_reg) + (my <<< COEF_FRAC_BITS);
		cx = trunc_q(ax);
		cy = trunc_q(ay);
		if (cx < 0) cx = 0;
		if (cx > w - 1) cx = w - 1;
		if (cy < 0) cy = 0;
		if (cy > h - 1) cy = h - 1;
		sx = XW'(w - 1 - cx);
		sy = YW'(cy);
	endfunction

	task automatic issue_beat(input action_t act, input logic [XW-1:0] x,
		input logic [YW-1:0] y, input logic [PIX_W-1:0] pix);
		rot_pixel_t r;
		@(negedge clk);
		// each cycle is idle with probability idle_pct percent
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start    <= 1'b1;
		action   <= act;
		coord_x  <= x;
		coord_y  <= y;
		pixel_in <= pix;
		do @(posedge clk); while (busy);
		beats_sent++;
		if (act == ACT_LOAD) begin
			frame_shadow[int'({y, x})] = pix;
		end else begin
			rotated_source(x, y, r.sx, r.sy);
			r.pixel = frame_shadow[int'({r.sy, r.sx})];
			pending_pixels.push_back(r);
		end
	endtask

	// fetch, loading the source pixel first if it was never written
	task automatic fetch_pixel(input logic [XW-1:0] x, input logic [YW-1:0] y);
		logic [XW-1:0] sx;
		logic [YW-1:0] sy;
		rotated_source(x, y, sx, sy);
		if (!frame_shadow.exists(int'({sy, sx}))) begin
			issue_beat(ACT_LOAD, sx, sy, $urandom());
		end
		issue_beat(ACT_FETCH, x, y, $urandom());
	endtask

	task automatic drain;
		@(negedge clk);
		start <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_WIDTH: begin
				width_reg = data[SIZE_W-1:0];
			end
			REG_HEIGHT: begin
				height_reg = data[SIZE_W-1:0];
			end
			REG_SIN: begin
				sin_reg = data[COEF_W-1:0];
			end
			REG_COS: begin
				cos_reg = data[COEF_W-1:0];
			end
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_read_check(input reg_idx_t idx);
		logic [PDATA_W-1:0] got;
		logic [COEF_W-1:0]  exp_v;
		logic [COEF_W-1:0]  got_v;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= PADDR_W'({idx, 2'b00});
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_WIDTH: begin
				exp_v = COEF_W'(width_reg);
				got_v = COEF_W'(got[SIZE_W-1:0]);
			end
			REG_HEIGHT: begin
				exp_v = COEF_W'(height_reg);
				got_v = COEF_W'(got[SIZE_W-1:0]);
			end
			REG_SIN: begin
				exp_v = sin_reg;
				got_v = got[COEF_W-1:0];
			end
			default: begin
				exp_v = cos_reg;
				got_v = got[COEF_W-1:0];
			end
		endcase
		if (got_v !== exp_v) begin
			mismatch_cnt++;
			if (mismatch_cnt <= 10)
				$display("register %s read: expected %h, got %h", idx.name(), exp_v, got_v);
		end
	endtask

	task automatic set_config(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
		input logic signed [COEF_W-1:0] s, input logic signed [COEF_W-1:0] c);
		drain();
		apb_write(REG_WIDTH, PDATA_W'(w));
		apb_write(REG_HEIGHT, PDATA_W'(h));
		apb_write(REG_SIN, PDATA_W'(s));
		apb_write(REG_COS, PDATA_W'(c));
		apb_read_check(REG_WIDTH);
		apb_read_check(REG_HEIGHT);
		apb_read_check(REG_SIN);
		apb_read_check(REG_COS);
	endtask

	// result beat checker
	always @(posedge clk) begin : result_check
		rot_pixel_t e;
		if (arst_n && done) begin
			if (pending_pixels.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected beat: pixel %h src (%0d,%0d)",
						pixel_out, source_x, source_y);
			end else begin
				e = pending_pixels.pop_front();
				if (pixel_out !== e.pixel || source_x !== e.sx || source_y !== e.sy) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("fetch beat: expected pixel %h src (%0d,%0d), got %h (%0d,%0d)",
							e.pixel, e.sx, e.sy, pixel_out, source_x, source_y);
				end
			end
		end
	end

	task automatic check_reset_values;
		apb_read_check(REG_WIDTH);
		apb_read_check(REG_HEIGHT);
		apb_read_check(REG_SIN);
		apb_read_check(REG_COS);
	endtask

	// default config: source is (511 - y, x), so corner fetches read corner loads
	task automatic test_store_corners;
		issue_beat(ACT_LOAD, 9'd0, 9'd0, 32'h0000_0000);
		issue_beat(ACT_LOAD, 9'd511, 9'd0, 32'hFFFF_FFFF);
		issue_beat(ACT_LOAD, 9'd0, 9'd511, 32'hAAAA_5555);
		issue_beat(ACT_LOAD, 9'd511, 9'd511, 32'h5555_AAAA);
		fetch_pixel(9'd0, 9'd0);
		fetch_pixel(9'd511, 9'd0);
		fetch_pixel(9'd0, 9'd511);
		fetch_pixel(9'd511, 9'd511);
	endtask

	// zero acts as one, oversize acts as the maximum
	task automatic test_size_extremes;
		set_config(10'd0, 10'd0, 16'sd0, 16'sd16384);
		fetch_pixel(9'd0, 9'd0);
		fetch_pixel(9'd511, 9'd511);
		set_config(10'd1023, 10'd1023, 16'sd0, 16'sd16384);
		fetch_pixel(9'd511, 9'd3);
		set_config(10'd1, 10'd512, 16'sd0, 16'sd16384);
		fetch_pixel(9'd0, 9'd511);
		set_config(10'd3, 10'd2, 16'sd0, 16'sd16384);
		fetch_pixel(9'd2, 9'd1);
	endtask

	// coefficients past +-1.0 are used as given; far coordinates hit the clamps
	task automatic test_coef_extremes;
		set_config(10'd512, 10'd512, -16'sd32768, 16'sd32767);
		fetch_pixel(9'd0, 9'd511);
		fetch_pixel(9'd300, 9'd200);
		set_config(10'd512, 10'd512, 16'sd16384, 16'sd0);
		fetch_pixel(9'd511, 9'd0);
		set_config(10'd200, 10'd100, -16'sd16384, -16'sd16384);
		fetch_pixel(9'd0, 9'd0);
		fetch_pixel(9'd150, 9'd60);
	endtask

	task automatic run_random_phase(input int n_items, input int idle_in_100,
		input bit extreme_cfg);
		logic [SIZE_W-1:0]        w, h;
		logic signed [COEF_W-1:0] s, c;
		int                       stop_at;
		int                       sel;
		longint                   we, he;
		if (extreme_cfg) begin
			w = ($urandom_range(1)) ? 10'd1023 : 10'd1;
			h = ($urandom_range(1)) ? 10'd512 : 10'd0;
			s = ($urandom_range(1)) ? 16'sh7FFF : -16'sd16384;
			c = ($urandom_range(1)) ? 16'sh8000 : 16'sd16384;
		end else begin
			w = ($urandom_range(3) == 0) ? SIZE_W'($urandom_range(2, 16))
				: SIZE_W'($urandom_range(1, 512));
			h = ($urandom_range(3) == 0) ? SIZE_W'($urandom_range(2, 16))
				: SIZE_W'($urandom_range(1, 512));
			s = ($urandom_range(7) == 0) ? COEF_W'($urandom()) : COEF_W'(int'($urandom_range(32768)) - 16384);
			c = ($urandom_range(7) == 0) ? COEF_W'($urandom()) : COEF_W'(int'($urandom_range(32768)) - 16384);
		end
		set_config(w, h, s, c);
		idle_pct = idle_in_100;
		we = eff_dim(width_reg, MAX_WIDTH);
		he = eff_dim(height_reg, MAX_HEIGHT);
		stop_at = beats_sent + n_items;
		while (beats_sent < stop_at) begin
			sel = $urandom_range(9);
			if (sel < 3) begin
				issue_beat(ACT_LOAD, XW'($urandom()), YW'($urandom()), $urandom());
			end else if (sel < 8) begin
				fetch_pixel(XW'($urandom_range(int'(we) - 1)), YW'($urandom_range(int'(he) - 1)));
			end else begin
				fetch_pixel(XW'($urandom()), YW'($urandom()));
			end
		end
		idle_pct = 0;
	endtask

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		start        = 1'b0;
		action       = ACT_LOAD;
		coord_x      = '0;
		coord_y      = '0;
		pixel_in     = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		width_reg    = WIDTH_RST;
		height_reg   = HEIGHT_RST;
		sin_reg      = SIN_RST;
		cos_reg      = COS_RST;
		mismatch_cnt = 0;
		beats_sent   = 0;
		idle_pct     = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		check_reset_values();
		test_store_corners();
		test_size_extremes();
		test_coef_extremes();
		run_random_phase(100, 0, 1'b0);
		run_random_phase(100, 58, 1'b0);
		run_random_phase(100, 14, 1'b0);
		run_random_phase(40, 58, 1'b1);
		run_random_phase(60, 0, 1'b0);

		drain();
		repeat (10) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/nrpf_pkg.sv
sv/nearest_rotation_pixel_fetch_unit.sv
tb/sv/nearest_rotation_pixel_fetch_unit_tb.sv
